### rtl/jcfe_pkg.sv
// shared constants, codes and helper functions of the json content field extractor
package jcfe_pkg;

    localparam int DEPTH_BITS = 16;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_DISCARD  = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [2:0] KEY_LEN = 3'd7;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    // "content"
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h63;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h6E;
            3'd3:    ch = 8'h74;
            3'd4:    ch = 8'h65;
            3'd5:    ch = 8'h6E;
            3'd6:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

### rtl/json_content_field_extractor_unit.sv
// json content field extractor: byte scanner with input and result registers
//
// usage
//   s_tdata carries one document byte per item, s_tlast marks the final byte.
//   m_tdata carries the decoded value byte, m_tuser the result kind
//   (0 value byte, 1 value complete, 2 unterminated, 3 no content found).
//   a byte gives zero or one result; the final byte of a document always
//   gives one unless the value completed earlier.
// throughput and pipeline
//   one item per cycle while no result is held or m_tready is high; a byte
//   passes the input register, then one scan-state update into the result
//   register. the scan-state update is the only loop.
// reset
//   rst_n clears the scan state and both valid flags; the block is ready
//   right after reset.
// stall
//   when m_tready is low and a result is held, the input register holds its
//   byte and s_tready falls once that register is full; no item is lost.
//   after the final byte the scan state returns to its reset value.
module json_content_field_extractor_unit
    import jcfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // value_byte[7:0]
    output logic [1:0] m_tuser    // kind[1:0]
);

    localparam logic [3:0] M_SCAN        = 4'd0;
    localparam logic [3:0] M_KEY         = 4'd1;
    localparam logic [3:0] M_AFTER_KEY   = 4'd2;
    localparam logic [3:0] M_AFTER_COLON = 4'd3;
    localparam logic [3:0] M_SKIP_STR    = 4'd4;
    localparam logic [3:0] M_SKIP_PRIM   = 4'd5;
    localparam logic [3:0] M_SKIP_CONT   = 4'd6;
    localparam logic [3:0] M_CONT_STR    = 4'd7;
    localparam logic [3:0] M_VALUE       = 4'd8;
    localparam logic [3:0] M_DONE        = 4'd9;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  advance;

    logic [3:0]            mode_reg, mode_next;
    logic [2:0]            idx_reg, idx_next;
    logic                  mismatch_reg, mismatch_next;
    logic                  esc_reg, esc_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  square_reg, square_next;
    logic                  done_reg, done_next;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic [1:0]            out_kind_reg;

    logic                  got;
    logic [1:0]            got_kind;
    logic [7:0]            got_byte;
    logic                  emit;
    logic [1:0]            emit_kind;
    logic [7:0]            emit_byte;
    logic [7:0]            c;
    logic [7:0]            key_in;
    logic                  key_feed;
    logic [7:0]            open_ch;
    logic [7:0]            close_ch;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign c        = in_byte_reg;
    assign open_ch  = square_reg ? CH_LSQUARE : CH_LBRACE;
    assign close_ch = square_reg ? CH_RSQUARE : CH_RBRACE;

    always_comb
    begin
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        mismatch_next = mismatch_reg;
        esc_next      = esc_reg;
        depth_next    = depth_reg;
        square_next   = square_reg;
        done_next     = done_reg;
        got           = 1'b0;
        got_kind      = KIND_BYTE;
        got_byte      = 8'h00;
        key_feed      = 1'b0;
        key_in        = c;

        case (mode_reg)
            M_SCAN:
            begin
                if (c == CH_QUOTE)
                begin
                    mode_next     = M_KEY;
                    idx_next      = 3'd0;
                    mismatch_next = 1'b0;
                    esc_next      = 1'b0;
                end
            end
            M_KEY:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    key_feed = 1'b1;
                    key_in   = unescape(c);
                end
                else if (c == CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == CH_QUOTE)
                    mode_next = M_AFTER_KEY;
                else
                    key_feed = 1'b1;
            end
            M_AFTER_KEY:
            begin
                if (!is_ws(c))
                begin
                    if (c == CH_COLON)
                        mode_next = M_AFTER_COLON;
                    else if (c == CH_QUOTE)
                    begin
                        mode_next     = M_KEY;
                        idx_next      = 3'd0;
                        mismatch_next = 1'b0;
                        esc_next      = 1'b0;
                    end
                    else
                        mode_next = M_SCAN;
                end
            end
            M_AFTER_COLON:
            begin
                if (!is_ws(c))
                begin
                    esc_next = 1'b0;
                    if (c == CH_QUOTE)
                        mode_next = (!mismatch_reg && idx_reg == KEY_LEN) ? M_VALUE
                                                                          : M_SKIP_STR;
                    else if (c == CH_LBRACE || c == CH_LSQUARE)
                    begin
                        mode_next   = M_SKIP_CONT;
                        depth_next  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
                        square_next = (c == CH_LSQUARE);
                    end
                    else if (c == CH_COMMA || c == CH_RBRACE || c == CH_RSQUARE)
                        mode_next = M_SCAN;
                    else
                        mode_next = M_SKIP_PRIM;
                end
            end
            M_SKIP_STR, M_CONT_STR:
            begin
                if (esc_reg)
                    esc_next = 1'b0;
                else if (c == CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == CH_QUOTE)
                    mode_next = (mode_reg == M_SKIP_STR) ? M_SCAN : M_SKIP_CONT;
            end
            M_SKIP_PRIM:
            begin
                if (c == CH_COMMA || c == CH_RBRACE || c == CH_RSQUARE)
                    mode_next = M_SCAN;
            end
            M_SKIP_CONT:
            begin
                if (c == CH_QUOTE)
                begin
                    mode_next = M_CONT_STR;
                    esc_next  = 1'b0;
                end
                else if (c == open_ch)
                begin
                    if (depth_reg != DEPTH_MAX)
                        depth_next = depth_reg + 1'b1;
                end
                else if (c == close_ch)
                begin
                    if (depth_reg != '0)
                        depth_next = depth_reg - 1'b1;
                    if (depth_reg <= {{(DEPTH_BITS-1){1'b0}}, 1'b1})
                        mode_next = M_SCAN;
                end
            end
            M_VALUE:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    got      = 1'b1;
                    got_byte = unescape(c);
                end
                else if (c == CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == CH_QUOTE)
                begin
                    mode_next = M_DONE;
                    done_next = 1'b1;
                    got       = 1'b1;
                    got_kind  = KIND_COMPLETE;
                end
                else
                begin
                    got      = 1'b1;
                    got_byte = c;
                end
            end
            default:
            begin
            end
        endcase

        // key compare against "content"
        if (key_feed && !mismatch_reg)
        begin
            if (idx_reg < KEY_LEN && key_in == key_char(idx_reg))
                idx_next = idx_reg + 1'b1;
            else
                mismatch_next = 1'b1;
        end

        emit      = got;
        emit_kind = got_kind;
        emit_byte = got_byte;

        // final byte of the document
        if (in_last_reg)
        begin
            emit      = 1'b1;
            emit_byte = 8'h00;
            if (got && got_kind == KIND_COMPLETE)
                emit_kind = KIND_COMPLETE;
            else if (mode_next == M_VALUE)
                emit_kind = KIND_DISCARD;
            else if (done_reg)
                emit = 1'b0;
            else
                emit_kind = KIND_NONE;

            mode_next     = M_SCAN;
            idx_next      = 3'd0;
            mismatch_next = 1'b0;
            esc_next      = 1'b0;
            depth_next    = '0;
            square_next   = 1'b0;
            done_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= M_SCAN;
            idx_reg       <= 3'd0;
            mismatch_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            depth_reg     <= '0;
            square_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= emit;
                mode_reg      <= mode_next;
                idx_reg       <= idx_next;
                mismatch_reg  <= mismatch_next;
                esc_reg       <= esc_next;
                depth_reg     <= depth_next;
                square_reg    <= square_next;
                done_reg      <= done_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_byte_reg <= emit_byte;
            out_kind_reg <= emit_kind;
        end
    end

    // completed value keeps the scanner parked
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> mode_reg == M_DONE)
        else $error("value done outside done mode");

    // container skip always holds a nonzero depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_SKIP_CONT || mode_reg == M_CONT_STR) |-> depth_reg != '0)
        else $error("container skip with zero depth");

    // pending escape only inside a string
    assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (mode_reg == M_KEY || mode_reg == M_SKIP_STR ||
                     mode_reg == M_CONT_STR || mode_reg == M_VALUE))
        else $error("escape pending outside a string");

    // final byte returns the scan state to reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (mode_reg == M_SCAN && !done_reg && !esc_reg))
        else $error("state not cleared after final byte");

    // non-byte results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != KIND_BYTE) |-> out_byte_reg == 8'h00)
        else $error("nonzero byte on status result");

endmodule
